// ===== sv/lgb_pkg.sv =====
// Shared types, sizes and operation codes for the largest need grant broker.
package lgb_pkg;

    // Number of requester slots and depth of the spare portion reserve.
    localparam int SLOTS         = 8;
    localparam int RESERVE_DEPTH = 16;

    // Fixed field widths of the message and result words.
    localparam int OP_W     = 2;
    localparam int REQ_W    = 3;
    localparam int AMOUNT_W = 16;
    localparam int TARGET_W = 3;
    localparam int NEED_W   = AMOUNT_W + 1;

    // Derived sizes.
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ADDR_W = (RESERVE_DEPTH > 1) ? $clog2(RESERVE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RESERVE_DEPTH + 1);

    // A need of minus one marks a slot that needs nothing.
    localparam logic signed [NEED_W-1:0] NEED_NONE = -NEED_W'(1);
    localparam logic signed [NEED_W-1:0] NEED_ZERO = '0;

    typedef enum logic [OP_W-1:0] {
        OP_NEED    = 2'd0,
        OP_SUCCESS = 2'd1,
        OP_REST    = 2'd2,
        OP_FINISH  = 2'd3
    } op_t;

    typedef logic signed [NEED_W-1:0] need_t;

    // Commands from the sequencer to the compare unit.
    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctrl_t;

    // Status of the compare unit back to the sequencer.
    typedef struct packed {
        logic [SLOT_W-1:0] idx;
        logic              last;
        logic              found;
        logic [SLOT_W-1:0] winner;
    } scan_stat_t;

    // Commands to the reserve stack.
    typedef struct packed {
        logic push;
        logic pop;
    } rsv_ctrl_t;

    // Status of the reserve stack.
    typedef struct packed {
        logic empty;
        logic full;
    } rsv_stat_t;

    // One result word.
    typedef struct packed {
        logic                grant_valid;
        logic [TARGET_W-1:0] grant_target;
        logic [AMOUNT_W-1:0] grant_amount;
        logic                stored;
        logic                reserve_overflow;
    } result_t;

endpackage

// ===== sv/largest_need_grant_broker.sv =====
// Top level of the largest need grant broker: sequencer, result register and ports.
//
//  channel | handshake              | word
//  --------+------------------------+--------------------------------------------
//  in      | in_valid / in_ready    | operation, requester, amount
//  out     | out_valid / out_ready  | grant_valid, grant_target, grant_amount,
//          |                        | stored, reserve_overflow
//
// One word is taken at a time, and in_ready is high only while the sequencer is idle.
// A rest word is taken, walked over every slot through the shared compare unit, decided,
// and its result is loaded into the output register. Need, success and finish words pass
// an execute step, a pop step if a need pops a portion, and the output register load.
// A stalled output keeps the next result in the sequencer; a new word can be taken while
// the output register waits. Reset sets every need to minus one and empties the reserve.
module largest_need_grant_broker
    import lgb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     operation,
    input  logic [REQ_W-1:0]    requester,
    input  logic [AMOUNT_W-1:0] amount,

    output logic                out_valid,
    input  logic                out_ready,
    output logic                grant_valid,
    output logic [TARGET_W-1:0] grant_target,
    output logic [AMOUNT_W-1:0] grant_amount,
    output logic                stored,
    output logic                reserve_overflow
);

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DECIDE = 6'b001000,
        S_POP    = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // The accepted word.
    op_t                 op_reg;
    op_t                 op_next;
    logic [REQ_W-1:0]    req_reg;
    logic [REQ_W-1:0]    req_next;
    logic [AMOUNT_W-1:0] amt_reg;
    logic [AMOUNT_W-1:0] amt_next;

    // Finished result waiting for the output register, and the output register.
    result_t res_reg;
    result_t res_next;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    out_load;

    // Sub-block connections.
    logic              tbl_we;
    need_t             tbl_wdata;
    need_t             tbl_rdata;
    scan_ctrl_t        scan_ctrl;
    scan_stat_t        scan_stat;
    rsv_ctrl_t         rsv_ctrl;
    rsv_stat_t         rsv_stat;
    logic [AMOUNT_W-1:0] rsv_pop_data;
    logic              req_in_range;
    logic              accept;

    assign in_ready     = (state_reg == S_IDLE);
    assign accept       = in_valid && in_ready;
    assign req_in_range = (32'(req_reg) < SLOTS);

    lgb_need_table u_need_table (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (tbl_we),
        .waddr (SLOT_W'(req_reg)),
        .wdata (tbl_wdata),
        .raddr (scan_stat.idx),
        .rdata (tbl_rdata)
    );

    lgb_scan_unit u_scan_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (scan_ctrl),
        .entry (tbl_rdata),
        .stat  (scan_stat)
    );

    lgb_reserve u_reserve (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rsv_ctrl),
        .push_data (amt_reg),
        .pop_data  (rsv_pop_data),
        .stat      (rsv_stat)
    );

    // Value written into the need table for the word at hand.
    always_comb
    begin
        unique case (op_reg)
            OP_NEED:    tbl_wdata = need_t'({1'b0, amt_reg});
            OP_SUCCESS: tbl_wdata = NEED_NONE;
            OP_FINISH:  tbl_wdata = NEED_ZERO;
            default:    tbl_wdata = NEED_ZERO;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        req_next        = req_reg;
        amt_next        = amt_reg;
        res_next        = res_reg;
        tbl_we          = 1'b0;
        scan_ctrl.clear = 1'b0;
        scan_ctrl.step  = 1'b0;
        rsv_ctrl.push   = 1'b0;
        rsv_ctrl.pop    = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = op_t'(operation);
                    req_next = requester;
                    amt_next = amount;
                    if (op_t'(operation) == OP_REST)
                    begin
                        scan_ctrl.clear = 1'b1;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC:
            begin
                // A requester beyond the slot count leaves everything alone.
                res_next   = '0;
                state_next = S_RESULT;
                if (req_in_range)
                begin
                    tbl_we = 1'b1;
                    if (op_reg == OP_NEED && !rsv_stat.empty)
                    begin
                        rsv_ctrl.pop          = 1'b1;
                        res_next.grant_valid  = 1'b1;
                        res_next.grant_target = TARGET_W'(req_reg);
                        state_next            = S_POP;
                    end
                end
            end

            S_POP:
            begin
                res_next.grant_amount = rsv_pop_data;
                state_next            = S_RESULT;
            end

            S_SCAN:
            begin
                scan_ctrl.step = 1'b1;
                if (scan_stat.last)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                // Grant to the largest need, else keep the portion in reserve.
                res_next   = '0;
                state_next = S_RESULT;
                if (scan_stat.found)
                begin
                    res_next.grant_valid  = 1'b1;
                    res_next.grant_target = TARGET_W'(scan_stat.winner);
                    res_next.grant_amount = amt_reg;
                end
                else if (!rsv_stat.full)
                begin
                    rsv_ctrl.push   = 1'b1;
                    res_next.stored = 1'b1;
                end
                else
                begin
                    res_next.reserve_overflow = 1'b1;
                end
            end

            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        req_reg <= req_next;
        amt_reg <= amt_next;
        res_reg <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign grant_valid      = out_reg.grant_valid;
    assign grant_target     = out_reg.grant_target;
    assign grant_amount     = out_reg.grant_amount;
    assign stored           = out_reg.stored;
    assign reserve_overflow = out_reg.reserve_overflow;

endmodule

// ===== sv/lgb_need_table.sv =====
// Per-slot signed need registers with one write port and one read port.
module lgb_need_table
    import lgb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [SLOT_W-1:0] waddr,
    input  need_t             wdata,
    input  logic [SLOT_W-1:0] raddr,
    output need_t             rdata
);

    need_t need_reg [SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                need_reg[i] <= NEED_NONE;
            end
        end
        else if (we)
        begin
            need_reg[waddr] <= wdata;
        end
    end

    assign rdata = need_reg[raddr];

endmodule

// ===== sv/lgb_reserve.sv =====
// Bounded LIFO of spare portions with a registered read port.
module lgb_reserve
    import lgb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  rsv_ctrl_t           ctrl,
    input  logic [AMOUNT_W-1:0] push_data,
    output logic [AMOUNT_W-1:0] pop_data,
    output rsv_stat_t           stat
);

    logic [AMOUNT_W-1:0] mem [RESERVE_DEPTH];
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    top_idx;
    logic [AMOUNT_W-1:0] rd_data_reg;

    assign top_idx    = count_reg - CNT_W'(1);
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(RESERVE_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = top_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // The sequencer only pushes when not full and pops when not empty.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[ADDR_W'(count_reg)] <= push_data;
        end
        if (ctrl.pop)
        begin
            rd_data_reg <= mem[ADDR_W'(top_idx)];
        end
    end

    assign pop_data = rd_data_reg;

endmodule

// ===== sv/lgb_scan_unit.sv =====
// Shared compare unit that walks the need table one entry per cycle while step is set.
module lgb_scan_unit
    import lgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  scan_ctrl_t ctrl,
    input  need_t      entry,
    output scan_stat_t stat
);

    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    logic              found_reg;
    logic              found_next;
    logic [SLOT_W-1:0] winner_reg;
    logic [SLOT_W-1:0] winner_next;
    need_t             best_reg;
    need_t             best_next;
    logic              better;

    // Strictly greater keeps the lowest index on ties; best starts at zero,
    // so only positive needs can win.
    assign better = (entry > best_reg);

    always_comb
    begin
        idx_next    = idx_reg;
        found_next  = found_reg;
        winner_next = winner_reg;
        best_next   = best_reg;
        if (ctrl.clear)
        begin
            idx_next    = '0;
            found_next  = 1'b0;
            winner_next = '0;
            best_next   = NEED_ZERO;
        end
        else if (ctrl.step)
        begin
            idx_next = idx_reg + SLOT_W'(1);
            if (better)
            begin
                found_next  = 1'b1;
                winner_next = idx_reg;
                best_next   = entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            found_reg  <= 1'b0;
            winner_reg <= '0;
            best_reg   <= NEED_ZERO;
        end
        else
        begin
            idx_reg    <= idx_next;
            found_reg  <= found_next;
            winner_reg <= winner_next;
            best_reg   <= best_next;
        end
    end

    assign stat.idx    = idx_reg;
    assign stat.last   = (idx_reg == SLOT_W'(SLOTS - 1));
    assign stat.found  = found_reg;
    assign stat.winner = winner_reg;

endmodule

// ===== sim/tb_largest_need_grant_broker.sv =====
// Self-checking testbench for the largest need grant broker.
module tb_largest_need_grant_broker;
    import lgb_pkg::*;

    // Flavors of random traffic. Starving traffic clears needs and returns
    // portions, so the reserve fills and overflows. Demanding traffic posts
    // needs, so the reserve drains and rest words turn into grants.
    typedef enum int {
        MIX_BALANCED,
        MIX_STARVE,
        MIX_DEMAND
    } mix_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     operation;
    logic [REQ_W-1:0]    requester;
    logic [AMOUNT_W-1:0] amount;
    logic                out_valid;
    logic                out_ready;
    logic                grant_valid;
    logic [TARGET_W-1:0] grant_target;
    logic [AMOUNT_W-1:0] grant_amount;
    logic                stored;
    logic                reserve_overflow;

    // Shadow copy of the broker state, advanced once per accepted input word.
    need_t               shadow_need [SLOTS];
    logic [AMOUNT_W-1:0] shadow_reserve [RESERVE_DEPTH];
    int                  shadow_depth;

    // Results still owed by the block, oldest first.
    result_t             owed_results [$];

    int                  fail_count;
    bit                  sender_idle_en;
    bit                  receiver_idle_en;
    int                  stall_left;

    largest_need_grant_broker dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .requester        (requester),
        .amount           (amount),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .grant_valid      (grant_valid),
        .grant_target     (grant_target),
        .grant_amount     (grant_amount),
        .stored           (stored),
        .reserve_overflow (reserve_overflow)
    );

    // Free-running clock with a period of 4.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one input word to the shadow state and return the result the
    // block must produce for it. A rest word scans for the largest strictly
    // positive need, keeping the lowest index on ties because only a larger
    // need replaces the current winner. With no positive need the portion
    // goes onto the reserve, or is dropped and flagged when the reserve is
    // full. A need word stores its amount and, if the reserve is not empty,
    // pops the most recently pushed portion and grants it to the sender.
    function automatic result_t grant_broker_step(input op_t op,
                                                  input logic [REQ_W-1:0] req,
                                                  input logic [AMOUNT_W-1:0] amt);
        result_t           res;
        need_t             best;
        logic [SLOT_W-1:0] winner;
        bit                found;
        res    = '0;
        best   = NEED_ZERO;
        winner = '0;
        found  = 1'b0;
        if (op == OP_REST)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (shadow_need[i] > best)
                begin
                    best   = shadow_need[i];
                    winner = SLOT_W'(i);
                    found  = 1'b1;
                end
            end
            if (found)
            begin
                res.grant_valid  = 1'b1;
                res.grant_target = TARGET_W'(winner);
                res.grant_amount = amt;
            end
            else if (shadow_depth < RESERVE_DEPTH)
            begin
                shadow_reserve[shadow_depth] = amt;
                shadow_depth++;
                res.stored = 1'b1;
            end
            else
            begin
                res.reserve_overflow = 1'b1;
            end
        end
        else if (int'(req) < SLOTS)
        begin
            // Slots beyond the table would be ignored; with eight slots and a
            // three-bit requester every index is in range.
            unique case (op)
                OP_NEED:
                begin
                    shadow_need[req] = need_t'({1'b0, amt});
                    if (shadow_depth > 0)
                    begin
                        shadow_depth--;
                        res.grant_valid  = 1'b1;
                        res.grant_target = TARGET_W'(req);
                        res.grant_amount = shadow_reserve[shadow_depth];
                    end
                end
                OP_SUCCESS: shadow_need[req] = NEED_NONE;
                default:    shadow_need[req] = NEED_ZERO;
            endcase
        end
        return res;
    endfunction

    // Offer one word on the input channel, optionally after a random gap, and
    // hold it until accepted. The task is entered and left at a rising edge,
    // and valid stays high on exit so back-to-back words never see a
    // lower-then-raise in the same time step.
    task automatic send_word(input op_t op, input logic [REQ_W-1:0] req,
                             input logic [AMOUNT_W-1:0] amt);
        int gap;
        gap = 0;
        if (sender_idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        requester <= req;
        amount    <= amt;
        do
            @(posedge clk);
        while (!in_ready);
        owed_results.push_back(grant_broker_step(op, req, amt));
    endtask

    // Amounts lean toward the edges: zero, all ones and small values show up
    // often, the rest is uniform over the full 16 bits.
    function automatic logic [AMOUNT_W-1:0] pick_amount();
        unique case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return AMOUNT_W'($urandom_range(1, 15));
            default: return AMOUNT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic op_t pick_op(input mix_t mix);
        int r;
        r = $urandom_range(0, 9);
        unique case (mix)
            MIX_STARVE:
                return (r < 1) ? OP_NEED : (r < 3) ? OP_SUCCESS :
                       (r < 4) ? OP_FINISH : OP_REST;
            MIX_DEMAND:
                return (r < 5) ? OP_NEED : (r < 6) ? OP_SUCCESS :
                       (r < 7) ? OP_FINISH : OP_REST;
            default:
                return (r < 3) ? OP_NEED : (r < 5) ? OP_SUCCESS :
                       (r < 8) ? OP_REST : OP_FINISH;
        endcase
    endfunction

    // A need with an empty reserve only records the need; a following rest
    // then grants straight to that slot. Success clears it again so the
    // reserve test starts with no positive need anywhere.
    task automatic test_need_then_rest();
        send_word(OP_NEED, 3'd4, 16'h8000);
        send_word(OP_REST, 3'd1, 16'h1234);
        send_word(OP_SUCCESS, 3'd4, 16'h0000);
    endtask

    // With every need at minus one, rest words fill the reserve: zero, all
    // ones and a walking one, seventeen portions in all, so the last is
    // dropped as an overflow.
    task automatic test_reserve_fill();
        send_word(OP_REST, 3'd0, 16'h0000);
        send_word(OP_REST, 3'd7, 16'hFFFF);
        for (int i = 0; i < 15; i++)
            send_word(OP_REST, REQ_W'(i), AMOUNT_W'(1) << i);
    endtask

    // Needs pop the reserve in last-in first-out order. A need of zero and a
    // finished slot are not positive, so a rest pushes. Equal needs go to the
    // lower slot, and a strictly larger need wins over both.
    task automatic test_pop_and_scan();
        send_word(OP_NEED, 3'd7, 16'hFFFF);
        send_word(OP_SUCCESS, 3'd7, 16'h0000);
        send_word(OP_NEED, 3'd0, 16'h0000);
        send_word(OP_FINISH, 3'd3, 16'h0000);
        send_word(OP_REST, 3'd6, 16'h5A5A);
        send_word(OP_NEED, 3'd5, 16'd100);
        send_word(OP_NEED, 3'd2, 16'd100);
        send_word(OP_REST, 3'd0, 16'hA5A5);
        send_word(OP_NEED, 3'd6, 16'd200);
        send_word(OP_REST, 3'd3, 16'hC3C3);
    endtask

    // Random traffic in phases of different flavor so the reserve swings
    // between empty and full many times. Most phases idle on both sides,
    // a few run flat out.
    task automatic test_random_phases(input int words);
        int   sent;
        int   len;
        mix_t mix;
        sent = 0;
        while (sent < words)
        begin
            mix              = mix_t'($urandom_range(0, 2));
            len              = $urandom_range(40, 120);
            sender_idle_en   = ($urandom_range(0, 4) != 0);
            receiver_idle_en = ($urandom_range(0, 4) != 0);
            for (int i = 0; i < len && sent < words; i++)
            begin
                send_word(pick_op(mix), REQ_W'($urandom_range(0, SLOTS - 1)),
                          pick_amount());
                sent++;
            end
        end
    endtask

    // Closing stretch at full rate on both channels.
    task automatic test_random_full_rate(input int words);
        sender_idle_en   = 1'b0;
        receiver_idle_en = 1'b0;
        for (int i = 0; i < words; i++)
            send_word(pick_op(mix_t'($urandom_range(0, 2))),
                      REQ_W'($urandom_range(0, SLOTS - 1)), pick_amount());
    endtask

    // Receiver: ready by default, with random stall bursts while enabled.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (receiver_idle_en && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 10);
        end
    end

    // Every accepted result word is matched against the oldest owed result.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result word with nothing owed: grant_valid=%0d stored=%0d",
                       grant_valid, stored);
                fail_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (grant_valid !== want.grant_valid)
                begin
                    $error("grant_valid: expected %0d, got %0d",
                           want.grant_valid, grant_valid);
                    fail_count++;
                end
                if (grant_target !== want.grant_target)
                begin
                    $error("grant_target: expected %0d, got %0d",
                           want.grant_target, grant_target);
                    fail_count++;
                end
                if (grant_amount !== want.grant_amount)
                begin
                    $error("grant_amount: expected %0h, got %0h",
                           want.grant_amount, grant_amount);
                    fail_count++;
                end
                if (stored !== want.stored)
                begin
                    $error("stored: expected %0d, got %0d", want.stored, stored);
                    fail_count++;
                end
                if (reserve_overflow !== want.reserve_overflow)
                begin
                    $error("reserve_overflow: expected %0d, got %0d",
                           want.reserve_overflow, reserve_overflow);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed tests, random tests, then drain.
    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        operation        = '0;
        requester        = '0;
        amount           = '0;
        out_ready        = 1'b0;
        stall_left       = 0;
        fail_count       = 0;
        sender_idle_en   = 1'b1;
        receiver_idle_en = 1'b1;
        for (int i = 0; i < SLOTS; i++)
            shadow_need[i] = NEED_NONE;
        shadow_depth = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_need_then_rest();
        test_reserve_fill();
        test_pop_and_scan();
        test_random_phases(1250);
        test_random_full_rate(150);
        in_valid <= 1'b0;

        // Wait for every owed result, then keep watching the output so a stray
        // extra result word would still be caught.
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (fail_count == 0 && owed_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of 1430 words.
    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
